### sv/dcci_pkg.sv
// Package: shared types, constants and helpers for the day-cycle color interpolator.
package dcci_pkg;

  localparam int unsigned DayMinutes = 1440;
  localparam int unsigned DayRecip   = 5965232;  // floor(2^33 / 1440)
  localparam int unsigned NumKeys    = 4;
  localparam int unsigned AddrW      = 5;

  typedef enum logic [2:0] {
    REG_TIME0  = 3'd0,
    REG_TIME1  = 3'd1,
    REG_TIME2  = 3'd2,
    REG_TIME3  = 3'd3,
    REG_COLOR0 = 3'd4,
    REG_COLOR1 = 3'd5,
    REG_COLOR2 = 3'd6,
    REG_COLOR3 = 3'd7
  } reg_idx_e;

  // classified beat handed from front to back
  typedef struct packed {
    logic [1:0]         seg;
    logic signed [12:0] offset;
    logic signed [12:0] length;
  } job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] level;
  } res_t;

  function automatic logic [7:0] chan(input logic [23:0] c, input logic [1:0] ch);
    logic [7:0] r;
    begin
      case (ch)
        2'd0:    r = c[23:16];
        2'd1:    r = c[15:8];
        default: r = c[7:0];
      endcase
      return r;
    end
  endfunction

  // x / 3 for x < 1024, by reciprocal
  function automatic logic [9:0] div3(input logic [9:0] x);
    logic [21:0] p;
    begin
      p = 22'(x) * 22'd1366;
      return p[21:12];
    end
  endfunction

endpackage

### sv/dcci_div.sv
// Pipelined signed restoring divider, one quotient bit per stage, truncating.
module dcci_div #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 14,
  parameter int unsigned SW = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  input  logic [SW-1:0]        side_i,
  output logic signed [NW-1:0] quo_o,
  output logic [SW-1:0]        side_o
);
  logic [NW-1:0] an;
  logic [NW-1:0] ad;
  logic [NW-1:0] rem_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [NW-1:0] den_q  [NW];
  logic          neg_q  [NW];
  logic [SW-1:0] side_q [NW];

  assign an = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign ad = den_i[DW-1] ? NW'(-{{(NW-DW){den_i[DW-1]}}, den_i})
                          : NW'({{(NW-DW){1'b0}}, den_i});

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] rem_s;
    logic [NW-1:0] quo_s;
    logic [NW-1:0] den_s;
    logic [NW-1:0] quo_n;
    logic          neg_s;
    logic [SW-1:0] side_s;
    logic [NW:0]   tr;
    logic [NW:0]   df;
    if (s == 0) begin : g_first
      assign rem_s  = '0;
      assign quo_s  = an;
      assign den_s  = ad;
      assign neg_s  = num_i[NW-1] ^ den_i[DW-1];
      assign side_s = side_i;
    end else begin : g_next
      assign rem_s  = rem_q[s-1];
      assign quo_s  = quo_q[s-1];
      assign den_s  = den_q[s-1];
      assign neg_s  = neg_q[s-1];
      assign side_s = side_q[s-1];
    end
    assign tr = {rem_s, quo_s[NW-1-s]};
    assign df = tr - {1'b0, den_s};
    always_comb begin
      quo_n = quo_s;
      quo_n[NW-1-s] = ~df[NW];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= df[NW] ? tr[NW-1:0] : df[NW-1:0];
        quo_q[s]  <= quo_n;
        den_q[s]  <= den_s;
        neg_q[s]  <= neg_s;
        side_q[s] <= side_s;
      end
    end
  end

  assign quo_o  = neg_q[NW-1] ? -$signed(quo_q[NW-1]) : $signed(quo_q[NW-1]);
  assign side_o = side_q[NW-1];
endmodule

### sv/dcci_front.sv
// Front end: minute reduction modulo a day and segment classification.
module dcci_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [30:0]       minutes_i,
  input  logic [10:0]       kt_i [4],
  output logic              valid_o,
  output dcci_pkg::job_t    job_o
);
  import dcci_pkg::*;

  // stage 1: quotient by reciprocal, low by at most one; stage 2: fix-up
  logic        v1_q, v2_q;
  logic [11:0] m1_q;
  logic [20:0] q1_q;
  logic [10:0] t_q;
  logic [53:0] prod;
  logic [11:0] r1;

  assign prod = 54'(minutes_i) * 54'(DayRecip);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= minutes_i[11:0];
      q1_q <= prod[53:33];
    end
  end
  // true remainder is below 2880, so the low 12 bits suffice
  assign r1 = m1_q - 12'(q1_q * 21'(DayMinutes));
  always_ff @(posedge clk_i) begin
    if (en_i) t_q <= (r1 >= 12'(DayMinutes)) ? 11'(r1 - 12'(DayMinutes)) : r1[10:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; valid_o <= v2_q;
    end
  end

  job_t job_d;
  always_comb begin
    logic signed [12:0] t, k0, k1, k2, k3;
    t = 13'(t_q); k0 = 13'(kt_i[0]); k1 = 13'(kt_i[1]);
    k2 = 13'(kt_i[2]); k3 = 13'(kt_i[3]);
    if (t >= k0 && t < k1) begin
      job_d.seg = 2'd0; job_d.offset = t - k0; job_d.length = k1 - k0;
    end else if (t >= k1 && t < k2) begin
      job_d.seg = 2'd1; job_d.offset = t - k1; job_d.length = k2 - k1;
    end else if (t >= k2 && t < k3) begin
      job_d.seg = 2'd2; job_d.offset = t - k2; job_d.length = k3 - k2;
    end else begin
      job_d.seg = 2'd3;
      job_d.offset = (t >= k3) ? t - k3 : t + 13'sd1440 - k3;
      job_d.length = 13'sd1440 - k3 + k0;
    end
    if (job_d.length == '0) job_d.length = 13'sd1;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) job_o <= job_d;
  end
endmodule

### sv/dcci_back.sv
// Back end: channel interpolation and light level through pipelined dividers.
module dcci_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  dcci_pkg::job_t job_i,
  input  logic [23:0]    kc_i [4],
  output logic           valid_o,
  output dcci_pkg::res_t res_o
);
  import dcci_pkg::*;

  localparam int unsigned Lat1 = 24;
  localparam int unsigned Lat2 = 18;

  // stage A: products
  logic signed [23:0] num [3];
  logic [7:0]         base [3];
  logic signed [23:0] num_q [3];
  logic [7:0]         base_q [3];
  logic signed [12:0] len_q;
  logic               va_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [9:0] d;
      base[c] = chan(kc_i[job_i.seg], 2'(c));
      d = 10'(chan(kc_i[job_i.seg + 2'd1], 2'(c))) - 10'(base[c]);
      num[c] = 24'(d) * 24'(job_i.offset);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num; base_q <= base; len_q <= job_i.length;
    end
  end

  logic signed [23:0] q [3];
  logic [23:0]        sd [3];
  for (genvar c = 0; c < 3; c++) begin : g_ch
    dcci_div #(.NW(24), .DW(13), .SW(24)) u_div (
      .clk_i, .en_i,
      .num_i(num_q[c]), .den_i(len_q), .side_i({16'd0, base_q[c]}),
      .quo_o(q[c]), .side_o(sd[c]));
  end

  logic [Lat1:0] vpipe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vpipe_q <= '0;
    else if (en_i) vpipe_q <= {vpipe_q[Lat1-1:0], valid_i};
  end
  assign va_q = vpipe_q[Lat1];

  // stage B: channels, averages, level numerator
  logic [7:0] rgb_q [3];
  logic signed [17:0] lnum_q;
  logic signed [10:0] lden_q;
  logic               zero_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [7:0] ch [3];
      logic [9:0] smx, smn, mx, mn, cur;
      smx = '0; smn = '0;
      for (int c = 0; c < 3; c++) begin
        logic [7:0] hi, lo;
        ch[c] = 8'(sd[c][7:0] + q[c][7:0]);
        hi = chan(kc_i[0], 2'(c)); lo = hi;
        for (int i = 1; i < 4; i++) begin
          if (chan(kc_i[i], 2'(c)) > hi) hi = chan(kc_i[i], 2'(c));
          if (chan(kc_i[i], 2'(c)) < lo) lo = chan(kc_i[i], 2'(c));
        end
        smx = smx + 10'(hi); smn = smn + 10'(lo);
      end
      mx = div3(smx); mn = div3(smn);
      cur = div3(10'(ch[0]) + 10'(ch[1]) + 10'(ch[2]));
      rgb_q  <= ch;
      lnum_q <= 18'($signed({1'b0, mx}) - $signed({1'b0, cur})) * 18'sd100;
      lden_q <= $signed({1'b0, mx}) - $signed({1'b0, mn});
      zero_q <= (mx == mn);
    end
  end
  logic vb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en_i) vb_q <= va_q;
  end

  logic signed [17:0] lq;
  logic [25:0]        lsd;
  dcci_div #(.NW(18), .DW(11), .SW(26)) u_ldiv (
    .clk_i, .en_i,
    .num_i(lnum_q), .den_i(zero_q ? 11'sd1 : lden_q),
    .side_i({zero_q, rgb_q[0], rgb_q[1], rgb_q[2], 1'b0}),
    .quo_o(lq), .side_o(lsd));

  logic [Lat2-1:0] v2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= '0;
    else if (en_i) v2_q <= {v2_q[Lat2-2:0], vb_q};
  end
  assign valid_o = v2_q[Lat2-1];

  always_comb begin
    res_o.red   = lsd[24:17];
    res_o.green = lsd[16:9];
    res_o.blue  = lsd[8:1];
    if (lsd[25] || lq < 0) res_o.level = '0;
    else if (lq > 18'sd100) res_o.level = 7'd100;
    else res_o.level = lq[6:0];
  end
endmodule

### sv/day_cycle_color_interpolator_core.sv
// Top level: config registers, front end, job queue and back end.
//  channel | dir | handshake       | payload
//  in      | in  | valid_i/stall_o | clock_minutes_i
//  out     | out | valid_o/stall_i | red_o green_o blue_o light_level_o
//  cfg     | in  | APB             | key times and colors
// One beat per cycle sustained while stall_i is low. An input beat passes
// through 3 front stages, the job queue, and the bit-per-stage dividers.
// stall_i freezes the back end when valid_o is set; jobs then collect in the
// QDepth-entry queue, and stall_o rises once it is full with a job waiting at
// the front's output. Reset restores the default key times and black colors.
module day_cycle_color_interpolator_core #(
  parameter int unsigned QDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [30:0] clock_minutes_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [6:0]  light_level_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [dcci_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dcci_pkg::*;

  localparam int unsigned PW = $clog2(QDepth);

  logic [10:0] kt_q [4];
  logic [23:0] kc_q [4];
  reg_idx_e    ridx;
  assign ridx   = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kt_q[0] <= 11'd300; kt_q[1] <= 11'd600; kt_q[2] <= 11'd1140; kt_q[3] <= 11'd1380;
      for (int i = 0; i < 4; i++) kc_q[i] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_TIME0:  kt_q[0] <= pwdata[10:0];
        REG_TIME1:  kt_q[1] <= pwdata[10:0];
        REG_TIME2:  kt_q[2] <= pwdata[10:0];
        REG_TIME3:  kt_q[3] <= pwdata[10:0];
        REG_COLOR0: kc_q[0] <= pwdata[23:0];
        REG_COLOR1: kc_q[1] <= pwdata[23:0];
        REG_COLOR2: kc_q[2] <= pwdata[23:0];
        REG_COLOR3: kc_q[3] <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_TIME0:  prdata = 32'(kt_q[0]);
      REG_TIME1:  prdata = 32'(kt_q[1]);
      REG_TIME2:  prdata = 32'(kt_q[2]);
      REG_TIME3:  prdata = 32'(kt_q[3]);
      REG_COLOR0: prdata = 32'(kc_q[0]);
      REG_COLOR1: prdata = 32'(kc_q[1]);
      REG_COLOR2: prdata = 32'(kc_q[2]);
      default:    prdata = 32'(kc_q[3]);
    endcase
  end

  // front -> job queue -> back, each side stalls on its own
  logic          fv;
  logic          f_en;
  logic          b_en;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  job_t          fjob;
  job_t          jq_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  res_t          bres;

  assign q_full  = cnt_q == (PW+1)'(QDepth);
  assign q_empty = cnt_q == '0;
  assign f_en    = !(fv && q_full);
  assign stall_o = !f_en;
  assign push    = fv && !q_full;
  assign b_en    = !(valid_o && stall_i);
  assign pop     = b_en && !q_empty;

  dcci_front u_front (.clk_i, .rst_ni, .en_i(f_en), .valid_i(valid_i && !stall_o),
    .minutes_i(clock_minutes_i), .kt_i(kt_q), .valid_o(fv), .job_o(fjob));
  dcci_back u_back (.clk_i, .rst_ni, .en_i(b_en), .valid_i(!q_empty), .job_i(jq_q[rp_q]),
    .kc_i(kc_q), .valid_o(valid_o), .res_o(bres));

  always_ff @(posedge clk_i) begin
    if (push) jq_q[wp_q] <= fjob;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assign red_o         = bres.red;
  assign green_o       = bres.green;
  assign blue_o        = bres.blue;
  assign light_level_o = bres.level;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_empty)) else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QDepth)) else $error("queue count out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(bres)) else $error("stalled beat changed");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> q_full) else $error("stall without full queue");
endmodule
